@@ design/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ design/hll_ws_pkg.sv @@
// fixed widths and constants of the hll wave-speed block
// no dependencies
package hll_ws_pkg;

    localparam int IN_W  = 24;
    localparam int OUT_W = 26;

    // gravity as a ratio, 9.81 = 981 / 100
    localparam int G_NUM = 981;
    localparam int G_DEN = 100;

endpackage

@@ design/hll_wave_speed_wet_dry_top.sv @@
// start passes through the product stage, the square root stages and stages a, b and c to done;
// the root is SW = (GW + 25) / 2 bits wide with GW the width of g; one transaction accepted every cycle, busy stays low
// the depth is set by the square root, which resolves one root bit per pipeline stage
// rst_n clears all valid bits asynchronously; data registers are not reset
// the receiver cannot stall: each result is shown on done for one cycle
// depends on hll_ws_pkg and assert_macros.svh
`include "assert_macros.svh"

module hll_wave_speed_wet_dry_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [hll_ws_pkg::IN_W-1:0]  vel_left,
    input  logic signed [hll_ws_pkg::IN_W-1:0]  vel_right,
    input  logic        [hll_ws_pkg::IN_W-1:0]  depth_left,
    input  logic        [hll_ws_pkg::IN_W-1:0]  depth_right,
    input  logic                                wet_left,
    input  logic                                wet_right,
    output logic                                done,
    output logic signed [hll_ws_pkg::OUT_W-1:0] speed_left,
    output logic signed [hll_ws_pkg::OUT_W-1:0] speed_right,
    output logic signed [hll_ws_pkg::OUT_W-1:0] speed_star
);
    import hll_ws_pkg::*;

    localparam longint unsigned G_FIXED =
        ((longint'(G_NUM) << FRAC_BITS) + longint'(G_DEN / 2)) / longint'(G_DEN);
    localparam int GW  = $clog2(G_FIXED + 1);
    localparam int SW  = (GW + IN_W + 1) / 2;      // root width
    localparam int PW  = 2 * SW;                   // radicand width, even
    localparam int SRW = SW + 2;                   // partial remainder width
    localparam int MW  = (SW > IN_W) ? SW : IN_W;
    localparam int WW  = MW + 4;                   // signed working width
    localparam int LAT = SW + 4;

    localparam logic signed [WW-1:0] SAT_HI = WW'((longint'(1) << (OUT_W - 1)) - 1);
    localparam logic signed [WW-1:0] SAT_LO = -SAT_HI - WW'(1);

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WW-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[OUT_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[OUT_W-1:0];
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

    assign busy = 1'b0;

    // ---------------- product stage and square root pipeline ----------------
    logic                   valid_reg [0:SW];
    logic signed [IN_W-1:0] ul_reg    [0:SW];
    logic signed [IN_W-1:0] ur_reg    [0:SW];
    logic                   wl_reg    [0:SW];
    logic                   wr_reg    [0:SW];

    logic [PW-1:0]  rad_reg  [0:1][0:SW];
    logic [SRW-1:0] rem_reg  [0:1][0:SW];
    logic [SW-1:0]  root_reg [0:1][0:SW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        ul_reg[0] <= vel_left;
        ur_reg[0] <= vel_right;
        wl_reg[0] <= wet_left;
        wr_reg[0] <= wet_right;
        rad_reg[0][0]  <= PW'(G_FIXED) * PW'(depth_left);
        rad_reg[1][0]  <= PW'(G_FIXED) * PW'(depth_right);
        rem_reg[0][0]  <= '0;
        rem_reg[1][0]  <= '0;
        root_reg[0][0] <= '0;
        root_reg[1][0] <= '0;
    end

    for (genvar s = 0; s < SW; s++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s+1] <= 1'b0;
            end
            else
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            ul_reg[s+1] <= ul_reg[s];
            ur_reg[s+1] <= ur_reg[s];
            wl_reg[s+1] <= wl_reg[s];
            wr_reg[s+1] <= wr_reg[s];
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [SRW-1:0] cand;
            logic [SRW-1:0] trial;
            logic [SRW:0]   diff;

            // bring down the next two radicand bits and try root bit one
            assign cand  = {rem_reg[l][s][SRW-3:0], rad_reg[l][s][PW-1 -: 2]};
            assign trial = {root_reg[l][s], 2'b01};
            assign diff  = {1'b0, cand} - {1'b0, trial};

            always_ff @(posedge clk)
            begin
                rad_reg[l][s+1] <= rad_reg[l][s] << 2;
                if (!diff[SRW])
                begin
                    rem_reg[l][s+1]  <= diff[SRW-1:0];
                    root_reg[l][s+1] <= {root_reg[l][s][SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[l][s+1]  <= cand;
                    root_reg[l][s+1] <= {root_reg[l][s][SW-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- stage a: sums of velocity and celerity ----------------
    logic signed [WW-1:0] ulx, urx, clx, crx;
    logic signed [WW-1:0] u_sum, u_dif, c_sum;
    logic signed [WW-1:0] us_next, ds_next;

    assign ulx   = WW'(ul_reg[SW]);
    assign urx   = WW'(ur_reg[SW]);
    assign clx   = $signed({{(WW - SW){1'b0}}, root_reg[0][SW]});
    assign crx   = $signed({{(WW - SW){1'b0}}, root_reg[1][SW]});
    assign u_sum = ulx + urx;
    assign u_dif = ulx - urx;
    assign c_sum = clx + crx;
    // floor halving and quartering by arithmetic shift
    assign us_next = (u_sum >>> 1) + clx - crx;
    assign ds_next = (c_sum >>> 1) + (u_dif >>> 2);

    logic                 a_valid_reg;
    logic                 a_wl_reg, a_wr_reg;
    logic signed [WW-1:0] a_us_reg, a_ds_reg;
    logic signed [WW-1:0] a_lw_reg, a_rw_reg;   // ul - cl, ur + cr
    logic signed [WW-1:0] a_ld_reg, a_rd_reg;   // ur - 2cr, ul + 2cl

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= valid_reg[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        a_wl_reg <= wl_reg[SW];
        a_wr_reg <= wr_reg[SW];
        a_us_reg <= us_next;
        a_ds_reg <= ds_next;
        a_lw_reg <= ulx - clx;
        a_rw_reg <= urx + crx;
        a_ld_reg <= urx - (crx <<< 1);
        a_rd_reg <= ulx + (clx <<< 1);
    end

    // ---------------- stage b: bounds and wet/dry selection ----------------
    logic signed [WW-1:0] lo_wet, hi_wet;
    logic signed [WW-1:0] sl_next, sr_next, ss_next;

    assign lo_wet = a_us_reg - a_ds_reg;
    assign hi_wet = a_us_reg + a_ds_reg;

    always_comb
    begin
        case ({a_wl_reg, a_wr_reg})
            2'b11:
            begin
                sl_next = (a_lw_reg < lo_wet) ? a_lw_reg : lo_wet;
                sr_next = (a_rw_reg > hi_wet) ? a_rw_reg : hi_wet;
                ss_next = a_us_reg;
            end
            2'b01:
            begin
                sl_next = a_ld_reg;
                sr_next = a_rw_reg;
                ss_next = a_ld_reg;
            end
            2'b10:
            begin
                sl_next = a_lw_reg;
                sr_next = a_rd_reg;
                ss_next = a_rd_reg;
            end
            default:
            begin
                sl_next = '0;
                sr_next = '0;
                ss_next = '0;
            end
        endcase
    end

    logic                 b_valid_reg;
    logic                 b_wl_reg, b_wr_reg;
    logic signed [WW-1:0] b_sl_reg, b_sr_reg, b_ss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_wl_reg <= a_wl_reg;
        b_wr_reg <= a_wr_reg;
        b_sl_reg <= sl_next;
        b_sr_reg <= sr_next;
        b_ss_reg <= ss_next;
    end

    // ---------------- stage c: saturation into the output registers ----------------
    logic                    done_reg;
    logic signed [OUT_W-1:0] speed_left_reg, speed_right_reg, speed_star_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        speed_left_reg  <= sat_out(b_sl_reg);
        speed_right_reg <= sat_out(b_sr_reg);
        speed_star_reg  <= sat_out(b_ss_reg);
    end

    assign done        = done_reg;
    assign speed_left  = speed_left_reg;
    assign speed_right = speed_right_reg;
    assign speed_star  = speed_star_reg;

    // ---------------- checks ----------------
    `ASSERT_IMPLY(a_fixed_latency, clk, rst_n, start && !busy, ##LAT done)
    `ASSERT_NEXT(a_dry_zero, clk, rst_n, b_valid_reg && !b_wl_reg && !b_wr_reg, speed_left == '0 && speed_right == '0 && speed_star == '0)
    `ASSERT_NEXT(a_left_dry_star, clk, rst_n, b_valid_reg && !b_wl_reg && b_wr_reg, speed_star == speed_left)
    `ASSERT_NEXT(a_right_dry_star, clk, rst_n, b_valid_reg && b_wl_reg && !b_wr_reg, speed_star == speed_right)

endmodule
